>>> hdl/dolc_pkg.sv
// Shared types and constants for the disciplined oscillator lock controller.
`timescale 1ns / 1ps
`default_nettype none

package dolc_pkg;

    typedef enum logic [3:0] {
        ST_START       = 4'd0,
        ST_SETUP       = 4'd1,
        ST_ERROR       = 4'd2,
        ST_FIXED       = 4'd3,
        ST_LOCKING     = 4'd4,
        ST_LOCKED      = 4'd5,
        ST_LOCKED_NOTP = 4'd6,
        ST_OUT_PHASE   = 4'd7,
        ST_FIXED_NOTP  = 4'd8
    } mode_t;

    // configuration register indexes
    localparam logic [2:0] REG_SAVED_DAC      = 3'd0;
    localparam logic [2:0] REG_VIDEO_STANDARD = 3'd1;
    localparam logic [2:0] REG_PHASE_TOL      = 3'd2;
    localparam logic [2:0] REG_LOCK_TIME      = 3'd3;
    localparam logic [2:0] REG_HOLDOVER_TIME  = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // control bits
    localparam logic [4:0] CB_STD   = 5'h01;
    localparam logic [4:0] CB_RESET = 5'h04;
    localparam logic [4:0] CB_FAST  = 5'h08;
    localparam logic [4:0] CB_FIXED = 5'h10;

    // blink patterns
    localparam logic [7:0] PAT_OFF         = 8'h00;
    localparam logic [7:0] PAT_FIXED       = 8'h33;
    localparam logic [7:0] PAT_LOCKING     = 8'h01;
    localparam logic [7:0] PAT_LOCKED_NOTP = 8'h05;
    localparam logic [7:0] PAT_OUT_PHASE   = 8'h15;
    localparam logic [7:0] PAT_ALL         = 8'hff;

    localparam logic [15:0] DEFAULT_DAC = 16'd18260;
    localparam logic [15:0] UNSET_DAC   = 16'hffff;

    // reset values of the configuration registers
    localparam logic [15:0] RST_SAVED_DAC     = 16'hffff;
    localparam logic [14:0] RST_PHASE_TOL     = 15'd40;
    localparam logic [15:0] RST_LOCK_TIME     = 16'd30;
    localparam logic [15:0] RST_HOLDOVER_TIME = 16'd300;

    // fixed dwell limits, in seconds
    localparam int SETUP_WAIT = 5;
    localparam int FIXED_WAIT = 3;

    typedef struct packed {
        logic [15:0] saved_dac;
        logic        video_standard;
        logic [14:0] phase_tolerance;
        logic [15:0] lock_time;
        logic [15:0] holdover_time;
    } cfg_t;

    typedef struct packed {
        logic               tp_valid;
        logic signed [15:0] phase_diff;
        logic [15:0]        dac_value;
        logic               gps_setup_ok;
    } tick_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] average_dac;
        logic [4:0]  control_bits;
        logic        lock_flag;
        logic [7:0]  pattern;
    } lock_state_t;

endpackage

`default_nettype wire

>>> hdl/dolc_step.sv
// Per-tick state transition: average, seconds counter, lock state and entry actions.
`timescale 1ns / 1ps
`default_nettype none

module dolc_step #(
    parameter int AVG_SHIFT   = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  dolc_pkg::cfg_t           cfg,
    input  dolc_pkg::tick_t          tick,
    input  dolc_pkg::lock_state_t    cur,
    input  wire  [COUNT_WIDTH-1:0]   cur_count,
    output dolc_pkg::lock_state_t    nxt,
    output logic [COUNT_WIDTH-1:0]   nxt_count,
    output logic                     load_now
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_W-1:0]       count_ext;
    logic [CMP_W-1:0]       lock_ext;
    logic [CMP_W-1:0]       hold_ext;
    logic [15:0]            avg_upd;
    logic signed [16:0]     pd_s;
    logic signed [16:0]     tol_s;
    logic signed [16:0]     ntol_s;
    logic                   in_window;
    logic                   out_window;
    logic                   over_lock;
    logic                   over_hold;
    dolc_pkg::mode_t        target;
    dolc_pkg::lock_state_t  mid;
    logic [COUNT_WIDTH-1:0] mid_count;

    assign count_inc = (cur_count != COUNT_MAX) ? cur_count + 1'b1 : cur_count;
    assign count_ext = CMP_W'(count_inc);
    assign lock_ext  = CMP_W'(cfg.lock_time);
    assign hold_ext  = CMP_W'(cfg.holdover_time);
    assign over_lock = count_ext > lock_ext;
    assign over_hold = count_ext > hold_ext;

    assign avg_upd = (cur.mode == dolc_pkg::ST_LOCKED)
                   ? cur.average_dac - (cur.average_dac >> AVG_SHIFT)
                     + (tick.dac_value >> AVG_SHIFT)
                   : cur.average_dac;

    assign pd_s       = 17'(tick.phase_diff);
    assign tol_s      = signed'({2'b00, cfg.phase_tolerance});
    assign ntol_s     = -tol_s;
    assign in_window  = (pd_s < tol_s) && (pd_s > ntol_s);
    assign out_window = (pd_s > tol_s) || (pd_s < ntol_s);

    // transition decision
    always_comb
    begin
        mid             = cur;
        mid.average_dac = avg_upd;
        mid_count       = count_inc;
        target          = cur.mode;
        case (cur.mode)
            dolc_pkg::ST_START:
            begin
                mid.average_dac  = (cfg.saved_dac == dolc_pkg::UNSET_DAC)
                                 ? dolc_pkg::DEFAULT_DAC : cfg.saved_dac;
                mid.control_bits = ({4'b0000, cfg.video_standard} & dolc_pkg::CB_STD)
                                 | dolc_pkg::CB_RESET | dolc_pkg::CB_FAST;
                mid.pattern      = dolc_pkg::PAT_ALL;
                target           = dolc_pkg::ST_SETUP;
            end
            dolc_pkg::ST_SETUP:
            begin
                if (count_inc > COUNT_WIDTH'(dolc_pkg::SETUP_WAIT))
                begin
                    target = tick.gps_setup_ok ? dolc_pkg::ST_FIXED : dolc_pkg::ST_ERROR;
                end
            end
            dolc_pkg::ST_ERROR:
            begin
                target = dolc_pkg::ST_ERROR;
            end
            dolc_pkg::ST_FIXED:
            begin
                if (tick.tp_valid)
                begin
                    if (count_inc > COUNT_WIDTH'(dolc_pkg::FIXED_WAIT))
                    begin
                        target = dolc_pkg::ST_LOCKING;
                    end
                end
                else
                begin
                    mid_count = '0;
                end
            end
            dolc_pkg::ST_LOCKING:
            begin
                if (!tick.tp_valid)
                begin
                    target = dolc_pkg::ST_FIXED;
                end
                else if (in_window)
                begin
                    if (over_lock)
                    begin
                        target = dolc_pkg::ST_LOCKED;
                    end
                end
                else
                begin
                    mid_count = '0;
                end
            end
            dolc_pkg::ST_LOCKED:
            begin
                if (!tick.tp_valid)
                begin
                    target = dolc_pkg::ST_LOCKED_NOTP;
                end
                else if (out_window)
                begin
                    target = dolc_pkg::ST_OUT_PHASE;
                end
            end
            dolc_pkg::ST_LOCKED_NOTP:
            begin
                if (tick.tp_valid)
                begin
                    target = dolc_pkg::ST_LOCKED;
                end
                else if (over_hold)
                begin
                    target = dolc_pkg::ST_FIXED_NOTP;
                end
            end
            dolc_pkg::ST_OUT_PHASE:
            begin
                if (in_window)
                begin
                    target = dolc_pkg::ST_LOCKED;
                end
                else if (!tick.tp_valid)
                begin
                    target = dolc_pkg::ST_LOCKED_NOTP;
                end
                else if (over_hold)
                begin
                    target = dolc_pkg::ST_LOCKING;
                end
            end
            dolc_pkg::ST_FIXED_NOTP:
            begin
                if (tick.tp_valid)
                begin
                    target = dolc_pkg::ST_LOCKING;
                end
            end
            default:
            begin
                target = dolc_pkg::ST_ERROR;
            end
        endcase
    end

    // entry actions on a state change
    always_comb
    begin
        nxt       = mid;
        nxt_count = mid_count;
        load_now  = 1'b0;
        if (target != cur.mode)
        begin
            nxt_count = '0;
            nxt.mode  = target;
            case (target)
                dolc_pkg::ST_SETUP:
                begin
                    nxt.pattern = dolc_pkg::PAT_OFF;
                end
                dolc_pkg::ST_FIXED:
                begin
                    nxt.pattern      = dolc_pkg::PAT_FIXED;
                    nxt.lock_flag    = 1'b0;
                    load_now         = 1'b1;
                    nxt.control_bits = mid.control_bits | dolc_pkg::CB_FIXED;
                end
                dolc_pkg::ST_LOCKING:
                begin
                    nxt.pattern      = dolc_pkg::PAT_LOCKING;
                    nxt.lock_flag    = 1'b0;
                    nxt.control_bits = (mid.control_bits
                                       & ~(dolc_pkg::CB_RESET | dolc_pkg::CB_FIXED))
                                     | dolc_pkg::CB_FAST;
                end
                dolc_pkg::ST_LOCKED:
                begin
                    nxt.pattern      = dolc_pkg::PAT_OFF;
                    nxt.lock_flag    = 1'b1;
                    nxt.control_bits = mid.control_bits
                                     & ~(dolc_pkg::CB_FAST | dolc_pkg::CB_FIXED);
                end
                dolc_pkg::ST_LOCKED_NOTP:
                begin
                    nxt.pattern      = dolc_pkg::PAT_LOCKED_NOTP;
                    load_now         = 1'b1;
                    nxt.control_bits = mid.control_bits | dolc_pkg::CB_FIXED;
                end
                dolc_pkg::ST_OUT_PHASE:
                begin
                    nxt.pattern = dolc_pkg::PAT_OUT_PHASE;
                end
                dolc_pkg::ST_FIXED_NOTP:
                begin
                    nxt.pattern      = dolc_pkg::PAT_ALL;
                    nxt.lock_flag    = 1'b0;
                    nxt.control_bits = mid.control_bits | dolc_pkg::CB_FIXED;
                end
                default:
                begin
                    nxt.mode    = dolc_pkg::ST_ERROR;
                    nxt.pattern = dolc_pkg::PAT_ALL;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/disciplined_oscillator_lock_control_unit.sv
// Top level of the disciplined oscillator lock controller.
`timescale 1ns / 1ps
`default_nettype none

// Lock controller for a disciplined oscillator, stepped once per pulse-per-second
// tick. Each request on the input channel is one tick (time-pulse valid, signed
// phase difference, live DAC word, receiver setup result); each tick produces
// exactly one result request carrying the lock state, the oscillator control
// bits, the locked flag, a holdover DAC load strobe with the averaged DAC word,
// and the status LED blink pattern. The first tick after reset performs start-up:
// it loads the DAC average from saved_dac (all ones selects the default word) and
// enters setup. A request is taken into an input register, worked through one
// combinational step against the held lock state, and lands in a result register,
// so a request can be accepted every cycle, and its result is offered from that
// register; the only thing that slows the input is a result held under
// out_stall while the input register is also full. Configuration registers are
// written through cfg_we/cfg_index/cfg_data and should only change while no
// request is in flight; saved_dac and video_standard act only at start-up.
module disciplined_oscillator_lock_control_unit #(
    parameter int AVG_SHIFT   = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,

    input  wire                                  cfg_we,
    input  wire  [dolc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [dolc_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire                                  tp_valid,
    input  wire  signed [15:0]                   phase_diff,
    input  wire  [15:0]                          dac_value,
    input  wire                                  gps_setup_ok,

    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic [3:0]                           lock_state,
    output logic [4:0]                           osc_control,
    output logic                                 locked,
    output logic                                 dac_load,
    output logic [15:0]                          dac_hold_value,
    output logic [7:0]                           blink_pattern
);

    // configuration
    dolc_pkg::cfg_t          cfg_reg;

    // input register
    logic                    in_valid_reg;
    logic                    in_valid_next;
    dolc_pkg::tick_t         tick_reg;

    // lock state
    dolc_pkg::lock_state_t   state_reg;
    dolc_pkg::lock_state_t   state_next;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic [COUNT_WIDTH-1:0]  count_next;
    logic                    load_next;

    // result register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [3:0]              lock_state_reg;
    logic [4:0]              osc_control_reg;
    logic                    locked_reg;
    logic                    dac_load_reg;
    logic [15:0]             dac_hold_reg;
    logic [7:0]              blink_reg;

    logic                    accept;
    logic                    advance;

    // Advance the held tick whenever the result register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.saved_dac       <= dolc_pkg::RST_SAVED_DAC;
            cfg_reg.video_standard  <= 1'b0;
            cfg_reg.phase_tolerance <= dolc_pkg::RST_PHASE_TOL;
            cfg_reg.lock_time       <= dolc_pkg::RST_LOCK_TIME;
            cfg_reg.holdover_time   <= dolc_pkg::RST_HOLDOVER_TIME;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dolc_pkg::REG_SAVED_DAC:      cfg_reg.saved_dac       <= cfg_data;
                dolc_pkg::REG_VIDEO_STANDARD: cfg_reg.video_standard  <= cfg_data[0];
                dolc_pkg::REG_PHASE_TOL:      cfg_reg.phase_tolerance <= cfg_data[14:0];
                dolc_pkg::REG_LOCK_TIME:      cfg_reg.lock_time       <= cfg_data;
                dolc_pkg::REG_HOLDOVER_TIME:  cfg_reg.holdover_time   <= cfg_data;
                default:                      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Control: valid flags of both register stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming tick.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg.tp_valid     <= tp_valid;
            tick_reg.phase_diff   <= phase_diff;
            tick_reg.dac_value    <= dac_value;
            tick_reg.gps_setup_ok <= gps_setup_ok;
        end
    end

    dolc_step #(
        .AVG_SHIFT   (AVG_SHIFT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .cfg       (cfg_reg),
        .tick      (tick_reg),
        .cur       (state_reg),
        .cur_count (count_reg),
        .nxt       (state_next),
        .nxt_count (count_next),
        .load_now  (load_next)
    );

    // Lock state: commit the step only when its result moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode         <= dolc_pkg::ST_START;
            state_reg.average_dac  <= '0;
            state_reg.control_bits <= '0;
            state_reg.lock_flag    <= 1'b0;
            state_reg.pattern      <= dolc_pkg::PAT_ALL;
            count_reg              <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lock_state_reg  <= 4'(state_next.mode);
            osc_control_reg <= state_next.control_bits;
            locked_reg      <= state_next.lock_flag;
            dac_load_reg    <= load_next;
            dac_hold_reg    <= state_next.average_dac;
            blink_reg       <= state_next.pattern;
        end
    end

    assign out_valid      = out_valid_reg;
    assign lock_state     = lock_state_reg;
    assign osc_control    = osc_control_reg;
    assign locked         = locked_reg;
    assign dac_load       = dac_load_reg;
    assign dac_hold_value = dac_hold_reg;
    assign blink_pattern  = blink_reg;

endmodule

`default_nettype wire

>>> hdl/dolc_checker.sv
// Port-level checker for the lock controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dolc_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_stall,
    input wire [3:0]  lock_state,
    input wire [4:0]  osc_control,
    input wire        locked,
    input wire        dac_load,
    input wire [15:0] dac_hold_value,
    input wire [7:0]  blink_pattern
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result holds its state, control bits, held DAC word and blink pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(lock_state) && $stable(osc_control)
            && $stable(dac_hold_value) && $stable(blink_pattern))
        else $error("stalled result changed");

    // The holdover load fires only on entry to a state that drives the held word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dac_load |->
            lock_state == 4'(dolc_pkg::ST_FIXED) || lock_state == 4'(dolc_pkg::ST_LOCKED_NOTP))
        else $error("DAC load outside fixed or holdover entry");

    // The locked flag is only seen in the locked family of states.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && locked |->
            lock_state == 4'(dolc_pkg::ST_LOCKED) || lock_state == 4'(dolc_pkg::ST_LOCKED_NOTP)
            || lock_state == 4'(dolc_pkg::ST_OUT_PHASE))
        else $error("locked flag outside locked states");

    // Fixed mode always shows its own blink pattern and the fixed control bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lock_state == 4'(dolc_pkg::ST_FIXED) |->
            blink_pattern == dolc_pkg::PAT_FIXED && osc_control[4])
        else $error("fixed state without its pattern or control bit");

endmodule

bind disciplined_oscillator_lock_control_unit dolc_checker u_dolc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .lock_state     (lock_state),
    .osc_control    (osc_control),
    .locked         (locked),
    .dac_load       (dac_load),
    .dac_hold_value (dac_hold_value),
    .blink_pattern  (blink_pattern)
);

`default_nettype wire

>>> verif/disciplined_oscillator_lock_control_unit_test.sv
// Self-checking bench for the lock controller: directed lock walk, random PPS ticks, backpressure.
`timescale 1ns / 1ps
module disciplined_oscillator_lock_control_unit_test;

    localparam int AVG_SHIFT   = 4;
    localparam int COUNT_WIDTH = 16;
    // Watchdog limit, with a wide margin over the slowest run.
    localparam int CYCLE_LIMIT = 200000;
    // Two register stages between the input and result ports, plus slack.
    localparam int DRAIN_PAUSE = 4;
    localparam int DIRECTED_TOL = 40;

    // One predicted result request, field for field.
    typedef struct packed {
        logic [3:0]  state;
        logic [4:0]  ctrl;
        logic        lck;
        logic        load;
        logic [15:0] hold;
        logic [7:0]  pat;
    } lock_status_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [dolc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dolc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             tp_valid = 1'b0;
    logic signed [15:0]               phase_diff = '0;
    logic [15:0]                      dac_value = '0;
    logic                             gps_setup_ok = 1'b0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [3:0]                       lock_state;
    logic [4:0]                       osc_control;
    logic                             locked;
    logic                             dac_load;
    logic [15:0]                      dac_hold_value;
    logic [7:0]                       blink_pattern;

    // Shadow copy of the lock controller: state plus configuration registers.
    dolc_pkg::mode_t        trk_mode = dolc_pkg::ST_START;
    logic [COUNT_WIDTH-1:0] trk_secs = '0;
    logic [15:0]            trk_avg = '0;
    logic [4:0]             trk_ctrl = '0;
    logic                   trk_lock = 1'b0;
    logic [7:0]             trk_pattern = dolc_pkg::PAT_ALL;
    logic [15:0]            shadow_saved_dac = dolc_pkg::RST_SAVED_DAC;
    logic                   shadow_video = 1'b0;
    logic [14:0]            shadow_tol = dolc_pkg::RST_PHASE_TOL;
    logic [15:0]            shadow_lock_time = dolc_pkg::RST_LOCK_TIME;
    logic [15:0]            shadow_holdover = dolc_pkg::RST_HOLDOVER_TIME;

    lock_status_t pending_status[$];
    int           error_count = 0;

    // Idle knobs, in percent of cycles, and the long receiver hold-off.
    int tick_gap_pct = 13;
    int result_stall_pct = 85;
    int hold_off_req = 0;
    int hold_off_left = 0;

    disciplined_oscillator_lock_control_unit #(
        .AVG_SHIFT   (AVG_SHIFT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .tp_valid       (tp_valid),
        .phase_diff     (phase_diff),
        .dac_value      (dac_value),
        .gps_setup_ok   (gps_setup_ok),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lock_state     (lock_state),
        .osc_control    (osc_control),
        .locked         (locked),
        .dac_load       (dac_load),
        .dac_hold_value (dac_hold_value),
        .blink_pattern  (blink_pattern)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply the entry actions of a new lock state; flag a holdover DAC load
    // when the state calls for one.
    task automatic enter_mode(input dolc_pkg::mode_t m, inout bit load);
        case (m)
            dolc_pkg::ST_SETUP:
                trk_pattern = dolc_pkg::PAT_OFF;
            dolc_pkg::ST_FIXED:
            begin
                trk_pattern = dolc_pkg::PAT_FIXED;
                trk_lock = 1'b0;
                load = 1'b1;
                trk_ctrl = trk_ctrl | dolc_pkg::CB_FIXED;
            end
            dolc_pkg::ST_LOCKING:
            begin
                trk_pattern = dolc_pkg::PAT_LOCKING;
                trk_lock = 1'b0;
                trk_ctrl = (trk_ctrl & ~dolc_pkg::CB_RESET & ~dolc_pkg::CB_FIXED)
                         | dolc_pkg::CB_FAST;
            end
            dolc_pkg::ST_LOCKED:
            begin
                trk_pattern = dolc_pkg::PAT_OFF;
                trk_lock = 1'b1;
                trk_ctrl = trk_ctrl & ~(dolc_pkg::CB_FAST | dolc_pkg::CB_FIXED);
            end
            dolc_pkg::ST_LOCKED_NOTP:
            begin
                trk_pattern = dolc_pkg::PAT_LOCKED_NOTP;
                load = 1'b1;
                trk_ctrl = trk_ctrl | dolc_pkg::CB_FIXED;
            end
            dolc_pkg::ST_OUT_PHASE:
                trk_pattern = dolc_pkg::PAT_OUT_PHASE;
            dolc_pkg::ST_FIXED_NOTP:
            begin
                trk_pattern = dolc_pkg::PAT_ALL;
                trk_lock = 1'b0;
                trk_ctrl = trk_ctrl | dolc_pkg::CB_FIXED;
            end
            default:
            begin
                // gps error, and anything unknown, lands here
                m = dolc_pkg::ST_ERROR;
                trk_pattern = dolc_pkg::PAT_ALL;
            end
        endcase
        trk_secs = '0;
        trk_mode = m;
    endtask

    // Step the shadow controller by one PPS tick and queue the result it owes.
    task automatic advance_lock_tracker(input logic tp, input logic signed [15:0] pd,
                                        input logic [15:0] dac, input logic ok);
        int              tol;
        bit              in_band;
        bit              out_band;
        bit              load;
        dolc_pkg::mode_t nxt;
        lock_status_t    status;
        tol = int'(shadow_tol);
        // strictly inside the window for locking, strictly beyond it for losing lock
        in_band = (int'(pd) < tol) && (int'(pd) > -tol);
        out_band = (int'(pd) > tol) || (int'(pd) < -tol);
        load = 1'b0;
        // Average only on ticks that begin locked.
        if (trk_mode == dolc_pkg::ST_LOCKED)
            trk_avg = trk_avg - (trk_avg >> AVG_SHIFT) + (dac >> AVG_SHIFT);
        if (trk_secs != {COUNT_WIDTH{1'b1}})
            trk_secs = trk_secs + 1'b1;
        nxt = trk_mode;
        case (trk_mode)
            dolc_pkg::ST_START:
            begin
                trk_avg = (shadow_saved_dac == dolc_pkg::UNSET_DAC)
                        ? dolc_pkg::DEFAULT_DAC : shadow_saved_dac;
                trk_ctrl = (shadow_video ? dolc_pkg::CB_STD : 5'd0)
                         | dolc_pkg::CB_RESET | dolc_pkg::CB_FAST;
                trk_pattern = dolc_pkg::PAT_ALL;
                nxt = dolc_pkg::ST_SETUP;
            end
            dolc_pkg::ST_SETUP:
            begin
                if (trk_secs > dolc_pkg::SETUP_WAIT)
                    nxt = ok ? dolc_pkg::ST_FIXED : dolc_pkg::ST_ERROR;
            end
            dolc_pkg::ST_ERROR:
                ;
            dolc_pkg::ST_FIXED:
            begin
                if (!tp)
                    trk_secs = '0;
                else if (trk_secs > dolc_pkg::FIXED_WAIT)
                    nxt = dolc_pkg::ST_LOCKING;
            end
            dolc_pkg::ST_LOCKING:
            begin
                if (!tp)
                    nxt = dolc_pkg::ST_FIXED;
                else if (in_band)
                begin
                    if (trk_secs > shadow_lock_time)
                        nxt = dolc_pkg::ST_LOCKED;
                end
                else
                    trk_secs = '0;
            end
            dolc_pkg::ST_LOCKED:
            begin
                if (!tp)
                    nxt = dolc_pkg::ST_LOCKED_NOTP;
                else if (out_band)
                    nxt = dolc_pkg::ST_OUT_PHASE;
            end
            dolc_pkg::ST_LOCKED_NOTP:
            begin
                if (tp)
                    nxt = dolc_pkg::ST_LOCKED;
                else if (trk_secs > shadow_holdover)
                    nxt = dolc_pkg::ST_FIXED_NOTP;
            end
            dolc_pkg::ST_OUT_PHASE:
            begin
                if (in_band)
                    nxt = dolc_pkg::ST_LOCKED;
                else if (!tp)
                    nxt = dolc_pkg::ST_LOCKED_NOTP;
                else if (trk_secs > shadow_holdover)
                    nxt = dolc_pkg::ST_LOCKING;
            end
            dolc_pkg::ST_FIXED_NOTP:
            begin
                if (tp)
                    nxt = dolc_pkg::ST_LOCKING;
            end
            default:
                nxt = dolc_pkg::ST_ERROR;
        endcase
        if (nxt != trk_mode)
            enter_mode(nxt, load);
        status.state = trk_mode;
        status.ctrl = trk_ctrl;
        status.lck = trk_lock;
        status.load = load;
        status.hold = trk_avg;
        status.pat = trk_pattern;
        pending_status.push_back(status);
    endtask

    // Offer one tick request, hold it until taken, then maybe leave a gap.
    task automatic send_tick(input logic tp, input logic signed [15:0] pd,
                             input logic [15:0] dac, input logic ok);
        in_valid <= 1'b1;
        tp_valid <= tp;
        phase_diff <= pd;
        dac_value <= dac;
        gps_setup_ok <= ok;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_lock_tracker(tp, pd, dac, ok);
        while ($urandom_range(99) < tick_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Mostly well-formed ticks: pulse present, phase inside the window; the
    // rest sits on the window edge, drops the pulse or is plain noise.
    task automatic send_random_tick();
        int                 tol;
        int                 pick;
        logic signed [15:0] pd;
        tol = int'(shadow_tol);
        pick = $urandom_range(99);
        if (pick < 70 && tol > 0)
            pd = 16'(int'($urandom_range(2 * tol - 2)) - (tol - 1));
        else if (pick < 88)
        begin
            case ($urandom_range(3))
                0: pd = 16'(tol);
                1: pd = 16'(-tol);
                2: pd = 16'(tol + 1);
                default: pd = 16'(-tol - 1);
            endcase
        end
        else
            pd = 16'($urandom);
        send_tick($urandom_range(99) < 88, pd, 16'($urandom), 1'($urandom));
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // Write one register; the spare cycle keeps write enable edges apart.
    task automatic write_reg(input logic [dolc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dolc_pkg::REG_SAVED_DAC:      shadow_saved_dac = val;
            dolc_pkg::REG_VIDEO_STANDARD: shadow_video = val[0];
            dolc_pkg::REG_PHASE_TOL:      shadow_tol = val[14:0];
            dolc_pkg::REG_LOCK_TIME:      shadow_lock_time = val;
            dolc_pkg::REG_HOLDOVER_TIME:  shadow_holdover = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_limits(input logic [14:0] tol, input logic [15:0] lock_secs,
                              input logic [15:0] hold_secs);
        drain_results();
        write_reg(dolc_pkg::REG_PHASE_TOL, {1'b0, tol});
        write_reg(dolc_pkg::REG_LOCK_TIME, lock_secs);
        write_reg(dolc_pkg::REG_HOLDOVER_TIME, hold_secs);
    endtask

    // Start-up tick loads the average from the saved word (all ones picks the
    // default), then six setup seconds end in fixed mode.
    task automatic test_startup();
        write_reg(dolc_pkg::REG_SAVED_DAC,
                  $urandom_range(1) ? dolc_pkg::UNSET_DAC : 16'($urandom));
        write_reg(dolc_pkg::REG_VIDEO_STANDARD, 16'd1);
        set_limits(15'(DIRECTED_TOL), 16'd2, 16'd3);
        send_tick(1'b1, 16'sh7fff, 16'hffff, 1'b1);
        send_tick(1'b0, -16'sd32768, 16'h0000, 1'b0);
        repeat (4) send_tick(1'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        send_tick(1'b1, 16'sd0, 16'h1234, 1'b1);
    endtask

    // Walk fixed -> locking -> locked -> out of phase -> locked -> holdover ->
    // locked -> holdover -> fixed no pulse -> locking, hitting tolerance edges.
    task automatic test_lock_acquire();
        // lost pulse in fixed clears the counter
        send_tick(1'b0, 16'sd0, 16'h0000, 1'b0);
        repeat (4) send_tick(1'b1, 16'sd0, 16'hffff, 1'b1);
        // locking: outside, then exactly on the edge, both reset the count
        send_tick(1'b1, 16'sh7fff, 16'h8000, 1'b0);
        send_tick(1'b1, 16'(-DIRECTED_TOL), 16'h0001, 1'b1);
        send_tick(1'b1, 16'(DIRECTED_TOL - 1), 16'h00ff, 1'b0);
        send_tick(1'b1, 16'(1 - DIRECTED_TOL), 16'hff00, 1'b1);
        send_tick(1'b1, 16'sd0, 16'h5555, 1'b0);
        // locked: averaging, on-edge phase keeps lock, extreme phase drops it
        send_tick(1'b1, 16'sd0, 16'hffff, 1'b1);
        send_tick(1'b1, 16'(DIRECTED_TOL), 16'haaaa, 1'b0);
        send_tick(1'b1, -16'sd32768, 16'h0000, 1'b1);
        send_tick(1'b1, 16'sd0, 16'h7777, 1'b0);
        // holdover on pulse loss, recover, then let holdover expire
        send_tick(1'b0, 16'sd0, 16'h1111, 1'b1);
        send_tick(1'b1, 16'sd0, 16'h2222, 1'b0);
        repeat (5) send_tick(1'b0, 16'($urandom), 16'($urandom), 1'($urandom));
        send_tick(1'b1, 16'sd0, 16'h3333, 1'b1);
    endtask

    task automatic test_random_traffic(input logic [14:0] tol, input logic [15:0] lock_secs,
                                       input logic [15:0] hold_secs, input int n_ticks);
        set_limits(tol, lock_secs, hold_secs);
        repeat (n_ticks) send_random_tick();
    endtask

    // Zero and all-ones limits: a zero window never counts as inside, an
    // all-ones time limit can never be exceeded.
    task automatic test_limit_extremes();
        test_random_traffic(15'd0, 16'hffff, 16'hffff, 40);
        test_random_traffic(15'h7fff, 16'd0, 16'd0, 40);
    endtask

    // Saved word and video standard only act at start-up; rewriting them now
    // must leave the outputs alone.
    task automatic test_late_startup_regs();
        drain_results();
        write_reg(dolc_pkg::REG_SAVED_DAC, 16'h0000);
        write_reg(dolc_pkg::REG_VIDEO_STANDARD, 16'd0);
        repeat (20) send_random_tick();
    endtask

    // Hold off the receiver long enough that the block backs up into its
    // input, keep offering ticks, then pause until everything is back.
    task automatic test_backpressure();
        hold_off_req = 150;
        repeat (24) send_random_tick();
        drain_results();
        repeat (12) send_random_tick();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Receiver: random stalls, or a long hold-off once one is requested.
    always @(posedge clk)
    begin
        if (hold_off_req != 0)
        begin
            hold_off_left = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left = hold_off_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < result_stall_pct);
    end

    // Match each accepted result request against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        lock_status_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                $error("result with no tick pending: lock_state %0d", lock_state);
                error_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("lock_state", want.state, lock_state);
                check_field("osc_control", want.ctrl, osc_control);
                check_field("locked", want.lck, locked);
                check_field("dac_load", want.load, dac_load);
                check_field("dac_hold_value", want.hold, dac_hold_value);
                check_field("blink_pattern", want.pat, blink_pattern);
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles now and then, receiver mostly stalls
        tick_gap_pct = 13;
        result_stall_pct = 85;
        test_startup();
        test_lock_acquire();
        test_random_traffic(15'($urandom_range(300, 20)), 16'($urandom_range(6)),
                            16'($urandom_range(6)), 100);
        test_limit_extremes();

        // swap: sender mostly idle, receiver rarely stalls
        tick_gap_pct = 85;
        result_stall_pct = 13;
        test_random_traffic(15'($urandom_range(300, 1)), 16'($urandom_range(8)),
                            16'($urandom_range(8)), 110);

        // full rate both ways
        tick_gap_pct = 0;
        result_stall_pct = 0;
        test_random_traffic(15'($urandom_range(200, 10)), 16'($urandom_range(4)),
                            16'($urandom_range(10)), 110);
        test_late_startup_regs();
        test_backpressure();

        drain_results();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
hdl/dolc_pkg.sv
hdl/dolc_step.sv
hdl/disciplined_oscillator_lock_control_unit.sv
hdl/dolc_checker.sv
verif/disciplined_oscillator_lock_control_unit_test.sv
